// File: rtl/axu_pkg.sv
// Shared types, codes and constants of the x86-64 add/subtract ALU.
package axu_pkg;

   // Operation codes carried in the func field
   typedef enum logic [3:0] {
      FUNC_ADD     = 4'd0,
      FUNC_ADC     = 4'd1,
      FUNC_SUB     = 4'd2,
      FUNC_SBB     = 4'd3,
      FUNC_CMP     = 4'd4,
      FUNC_NEG     = 4'd5,
      FUNC_INC     = 4'd6,
      FUNC_DEC     = 4'd7,
      FUNC_XADD    = 4'd8,
      FUNC_CMPXCHG = 4'd9,
      FUNC_CDQE    = 4'd10,
      FUNC_CQO     = 4'd11
   } func_type;

   // Operand forms
   typedef enum logic [2:0] {
      FORM_RM_REG  = 3'd0,   // dst = reg[rm], src = reg[reg]
      FORM_MEM_REG = 3'd1,   // dst = memory,  src = reg[reg]
      FORM_REG_RM  = 3'd2,   // dst = reg[reg], src = reg[rm]
      FORM_RM_IMM  = 3'd3,   // dst = reg[rm], src = immediate
      FORM_MEM_IMM = 3'd4    // dst = memory,  src = immediate
   } form_type;

   // Bit positions in the flag word
   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_AF = 2;
   localparam int FLAG_ZF = 3;
   localparam int FLAG_SF = 4;
   localparam int FLAG_OF = 5;
   localparam int FLAG_W  = 6;

   // Fixed register numbers
   localparam logic [3:0] ACC_INDEX = 4'd0;   // RAX
   localparam logic [3:0] RDX_INDEX = 4'd2;   // RDX

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 72;

   // One instruction item
   typedef struct packed {
      logic [3:0]         func;
      logic [2:0]         operand_form;
      logic [3:0]         reg_index;
      logic [3:0]         rm_index;
      logic signed [31:0] immediate;
      logic [63:0]        memory_value;
   } req_item_type;

   // One register file write port
   typedef struct packed {
      logic        en;
      logic [3:0]  idx;
      logic [63:0] data;
   } wr_port_type;

endpackage

// File: rtl/axu_regfile.sv
// General purpose register file: three read ports, two write ports.
module axu_regfile
   import axu_pkg::*;
#(
   parameter int REGISTER_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  rd_a_idx,
   input  logic [3:0]  rd_b_idx,
   input  logic [3:0]  rd_c_idx,
   output logic [63:0] rd_a_data,
   output logic [63:0] rd_b_data,
   output logic [63:0] rd_c_data,
   input  wr_port_type wr_a,    // lower priority
   input  wr_port_type wr_b     // wins when both hit one register
);

   localparam int IDX_W = $clog2(REGISTER_COUNT);
   localparam logic [4:0] COUNT_L = 5'(REGISTER_COUNT);

   logic [63:0] regs_ff [REGISTER_COUNT];

   // Indices past the file read as zero
   assign rd_a_data = ({1'b0, rd_a_idx} < COUNT_L) ? regs_ff[rd_a_idx[IDX_W-1:0]] : '0;
   assign rd_b_data = ({1'b0, rd_b_idx} < COUNT_L) ? regs_ff[rd_b_idx[IDX_W-1:0]] : '0;
   assign rd_c_data = ({1'b0, rd_c_idx} < COUNT_L) ? regs_ff[rd_c_idx[IDX_W-1:0]] : '0;

   // Writes past the file are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (wr_a.en && ({1'b0, wr_a.idx} < COUNT_L)) begin
            regs_ff[wr_a.idx[IDX_W-1:0]] <= wr_a.data;
         end
         if (wr_b.en && ({1'b0, wr_b.idx} < COUNT_L)) begin
            regs_ff[wr_b.idx[IDX_W-1:0]] <= wr_b.data;
         end
      end
   end

endmodule

// File: rtl/axu_exec.sv
// Execute logic: operand selection, shared 64-bit adder, flags and writebacks.
module axu_exec
   import axu_pkg::*;
(
   input  req_item_type      item,
   input  logic [63:0]       dst_val,
   input  logic [63:0]       src_val,
   input  logic [63:0]       acc_val,
   input  logic [FLAG_W-1:0] flags,
   output logic [3:0]        dst_idx,
   output logic [3:0]        src_idx,
   output wr_port_type       wr_a,
   output wr_port_type       wr_b,
   output logic              flags_we,
   output logic [FLAG_W-1:0] flags_next,
   output logic              mem_write,
   output logic [63:0]       mem_data
);

   logic        dst_mem;
   logic        src_is_reg;
   logic        form_ok;
   logic        cin;
   logic [63:0] a;
   logic [63:0] b;
   logic [63:0] op_x;
   logic [63:0] op_y;
   logic        op_c;
   logic        op_sub;
   logic [63:0] y_eff;
   logic [64:0] sum;
   logic [63:0] r;
   logic [63:0] af_vec;
   logic [63:0] of_vec;
   logic [FLAG_W-1:0] arith_flags;
   logic [63:0] res;
   logic        wr;

   // Operand routing by form
   always_comb begin
      form_ok    = (item.operand_form <= FORM_MEM_IMM);
      dst_mem    = (item.operand_form == FORM_MEM_REG) || (item.operand_form == FORM_MEM_IMM);
      src_is_reg = (item.operand_form == FORM_RM_REG) || (item.operand_form == FORM_MEM_REG) ||
                   (item.operand_form == FORM_REG_RM);
      dst_idx    = (item.operand_form == FORM_REG_RM) ? item.reg_index : item.rm_index;
      src_idx    = (item.operand_form == FORM_REG_RM) ? item.rm_index : item.reg_index;
      a          = dst_mem ? item.memory_value : dst_val;
      b          = src_is_reg ? src_val : {{32{item.immediate[31]}}, item.immediate};
      cin        = flags[FLAG_CF];
   end

   // Adder operands per operation
   always_comb begin
      op_x   = a;
      op_y   = b;
      op_c   = 1'b0;
      op_sub = 1'b0;
      case (item.func)
         FUNC_ADD:     ;
         FUNC_ADC:     op_c = cin;
         FUNC_SUB:     op_sub = 1'b1;
         FUNC_SBB: begin
            op_sub = 1'b1;
            op_c   = cin;
         end
         FUNC_CMP:     op_sub = 1'b1;
         FUNC_NEG: begin
            op_x   = '0;
            op_y   = a;
            op_sub = 1'b1;
         end
         FUNC_INC:     op_y = 64'd1;
         FUNC_DEC: begin
            op_y   = 64'd1;
            op_sub = 1'b1;
         end
         FUNC_XADD:    ;
         FUNC_CMPXCHG: begin
            op_x   = acc_val;
            op_y   = a;
            op_sub = 1'b1;
         end
         default:      ;
      endcase
   end

   // Shared adder; subtract is add of the complement, borrow is inverted carry
   always_comb begin
      y_eff  = op_sub ? ~op_y : op_y;
      sum    = {1'b0, op_x} + {1'b0, y_eff} + {64'd0, op_c ^ op_sub};
      r      = sum[63:0];
      af_vec = op_x ^ op_y ^ r;
      of_vec = op_sub ? ((op_x ^ op_y) & (op_x ^ r)) : ((op_x ^ r) & (op_y ^ r));
      arith_flags[FLAG_CF] = sum[64] ^ op_sub;
      arith_flags[FLAG_PF] = ~^r[7:0];
      arith_flags[FLAG_AF] = af_vec[4];
      arith_flags[FLAG_ZF] = (r == '0);
      arith_flags[FLAG_SF] = r[63];
      arith_flags[FLAG_OF] = of_vec[63];
   end

   // Writebacks and new flags
   always_comb begin
      wr_a       = '0;
      wr_b       = '0;
      flags_we   = 1'b0;
      flags_next = flags;
      mem_write  = 1'b0;
      mem_data   = '0;
      res        = r;
      wr         = 1'b1;
      if (item.func == FUNC_CDQE) begin
         wr_b = '{en: 1'b1, idx: ACC_INDEX, data: {{32{acc_val[31]}}, acc_val[31:0]}};
      end else if (item.func == FUNC_CQO) begin
         wr_b = '{en: 1'b1, idx: RDX_INDEX,
                  data: ((acc_val & SIGN_BIT) != '0) ? ALL_ONES : '0};
      end else if ((item.func <= FUNC_CMPXCHG) && form_ok) begin
         flags_we   = 1'b1;
         flags_next = arith_flags;
         // INC and DEC keep the carry
         if ((item.func == FUNC_INC) || (item.func == FUNC_DEC)) begin
            flags_next[FLAG_CF] = cin;
         end
         if (item.func == FUNC_CMP) begin
            wr = 1'b0;
         end else if (item.func == FUNC_XADD) begin
            if (src_is_reg) begin
               wr_a = '{en: 1'b1, idx: src_idx, data: a};
            end
         end else if (item.func == FUNC_CMPXCHG) begin
            // equality taken from the zero flag of acc - dst
            if (arith_flags[FLAG_ZF]) begin
               res = b;
            end else begin
               wr_a = '{en: 1'b1, idx: ACC_INDEX, data: a};
               res  = a;
               wr   = dst_mem;
            end
         end
         if (wr) begin
            if (dst_mem) begin
               mem_write = 1'b1;
               mem_data  = res;
            end else begin
               wr_b = '{en: 1'b1, idx: dst_idx, data: res};
            end
         end
      end
   end

endmodule

// File: rtl/x86_64_add_sub_alu_unit_top.sv
// Top level of the x86-64 add/subtract ALU: input register, execute, result register.
//
// Usage:
//   req_* carries one instruction item per handshake (tvalid & tready).
//   rsp_* returns one result item per instruction: memory write request and
//   the six arithmetic flags as they stand after the instruction.
//   The block keeps 16 (REGISTER_COUNT) 64-bit registers and the flags.
// Timing:
//   An accepted item is held in the input register; from there it executes
//   against the register file and flags and lands in the result register when it
//   can advance, which raises rsp_tvalid.
//   Throughput is one item per cycle while rsp_tready stays high: the adder,
//   flag logic and register file write all fit in the execute stage, and the next
//   item reads the updated registers and flags directly.
// Reset:
//   Synchronous; clears all general purpose registers, the flags and both valid stages.
// Stalls:
//   When rsp_tready is low the result holds, the waiting item stays in the
//   input register and req_tready drops while that register cannot advance.
module x86_64_add_sub_alu_unit_top
   import axu_pkg::*;
#(
   parameter int REGISTER_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func[3:0], operand_form[6:4], reg_index[10:7], rm_index[14:11],
   // immediate[46:15], memory_value[110:47], zero [111]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mem_write[0], mem_data[64:1], carry_flag[65], parity_flag[66],
   // adjust_flag[67], zero_flag[68], sign_flag[69], overflow_flag[70], zero [71]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_item_type          item_ff, item_in;
   logic                  in_valid_ff;
   logic [FLAG_W-1:0]     flags_ff, flags_in;
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  advance;

   logic [3:0]        dst_idx;
   logic [3:0]        src_idx;
   logic [63:0]       dst_val;
   logic [63:0]       src_val;
   logic [63:0]       acc_val;
   wr_port_type       wr_a, wr_b, wr_a_g, wr_b_g;
   logic              flags_we;
   logic [FLAG_W-1:0] flags_next;
   logic              mem_write;
   logic [63:0]       mem_data;

   // Handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Unpack the input item
   always_comb begin
      item_in.func         = req_tdata[3:0];
      item_in.operand_form = req_tdata[6:4];
      item_in.reg_index    = req_tdata[10:7];
      item_in.rm_index     = req_tdata[14:11];
      item_in.immediate    = req_tdata[46:15];
      item_in.memory_value = req_tdata[110:47];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   axu_regfile #(
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_a_idx  (dst_idx),
      .rd_b_idx  (src_idx),
      .rd_c_idx  (ACC_INDEX),
      .rd_a_data (dst_val),
      .rd_b_data (src_val),
      .rd_c_data (acc_val),
      .wr_a      (wr_a_g),
      .wr_b      (wr_b_g)
   );

   axu_exec u_exec (
      .item       (item_ff),
      .dst_val    (dst_val),
      .src_val    (src_val),
      .acc_val    (acc_val),
      .flags      (flags_ff),
      .dst_idx    (dst_idx),
      .src_idx    (src_idx),
      .wr_a       (wr_a),
      .wr_b       (wr_b),
      .flags_we   (flags_we),
      .flags_next (flags_next),
      .mem_write  (mem_write),
      .mem_data   (mem_data)
   );

   // State updates only when the item moves to the result register
   always_comb begin
      wr_a_g      = wr_a;
      wr_a_g.en   = wr_a.en && advance;
      wr_b_g      = wr_b;
      wr_b_g.en   = wr_b.en && advance;
      flags_in    = flags_we ? flags_next : flags_ff;
      out_data_in = {1'b0, flags_in, mem_data, mem_write};
   end

   // Flags register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Checks
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("executed item did not reach the result register");

   a_blocked_item_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("blocked item lost from the input register");

   a_flags_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff))
      else $error("flags changed without an executed item");

   a_result_flags_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_tdata[70:65] == flags_ff))
      else $error("result flags differ from the flag register");

endmodule
